// ----- rtl/core/nce_pkg.sv -----
// types, constants and helper functions shared by the noise channel modules
`default_nettype none

package nce_pkg;

   localparam int TIMER_W = 22;

   localparam logic [2:0] FUNC_READ = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_FREQ_TICK = 3'd2;
   localparam logic [2:0] FUNC_ENV_TICK = 3'd3;
   localparam logic [2:0] FUNC_LEN_TICK = 3'd4;

   localparam logic [2:0] REG_NR41 = 3'd1;
   localparam logic [2:0] REG_NR42 = 3'd2;
   localparam logic [2:0] REG_NR43 = 3'd3;
   localparam logic [2:0] REG_NR44 = 3'd4;

   localparam logic [14:0] LFSR_ALL_ONES = 15'h7FFF;
   localparam logic [7:0] DAC_MASK = 8'hF8;
   localparam logic [6:0] LENGTH_FULL = 7'd64;
   localparam logic [3:0] VOLUME_MAX = 4'd15;
   localparam logic [3:0] ENV_RELOAD = 4'd8;

   typedef struct packed {
      logic [2:0] func;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] sample_volume;
      logic length_running;
      logic channel_on;
   } rsp_type;

   function automatic logic [6:0] divisor_lookup(input logic [2:0] code);
      logic [6:0] d;
      case (code)
         3'd0: d = 7'd8;
         3'd1: d = 7'd16;
         3'd2: d = 7'd32;
         3'd3: d = 7'd48;
         3'd4: d = 7'd64;
         3'd5: d = 7'd80;
         3'd6: d = 7'd96;
         3'd7: d = 7'd112;
         default: d = 7'd8;
      endcase
      return d;
   endfunction

   function automatic logic [TIMER_W-1:0] timer_period(input logic [2:0] code,
                                                       input logic [3:0] shift);
      logic [TIMER_W-1:0] base;
      base = {{(TIMER_W-7){1'b0}}, divisor_lookup(code)};
      return base << shift;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nce_core.sv -----
// channel state registers and the per-transaction update logic
`default_nettype none

module nce_core
   import nce_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic step,
   input wire req_type item,
   output rsp_type result
);

   logic [5:0] length_load_ff, length_load_in;
   logic [6:0] length_count_ff, length_count_in;
   logic dac_on_ff, dac_on_in;
   logic [3:0] volume_load_ff, volume_load_in;
   logic env_increase_ff, env_increase_in;
   logic [2:0] env_period_load_ff, env_period_load_in;
   logic [3:0] env_period_count_ff, env_period_count_in;
   logic [3:0] volume_ff, volume_in;
   logic [2:0] divisor_code_ff, divisor_code_in;
   logic narrow_mode_ff, narrow_mode_in;
   logic [3:0] clock_shift_ff, clock_shift_in;
   logic length_enable_ff, length_enable_in;
   logic trigger_flag_ff, trigger_flag_in;
   logic [TIMER_W-1:0] freq_timer_ff, freq_timer_in;
   logic [14:0] shift_reg_ff, shift_reg_in;
   logic enabled_ff, enabled_in;
   logic env_running_ff, env_running_in;
   logic [3:0] out_volume_ff, out_volume_in;

   always_comb begin
      logic [7:0] rd;
      logic [7:0] d;
      logic fb;
      logic [14:0] sr;
      logic [3:0] vol;
      logic [6:0] len;

      length_load_in = length_load_ff;
      length_count_in = length_count_ff;
      dac_on_in = dac_on_ff;
      volume_load_in = volume_load_ff;
      env_increase_in = env_increase_ff;
      env_period_load_in = env_period_load_ff;
      env_period_count_in = env_period_count_ff;
      volume_in = volume_ff;
      divisor_code_in = divisor_code_ff;
      narrow_mode_in = narrow_mode_ff;
      clock_shift_in = clock_shift_ff;
      length_enable_in = length_enable_ff;
      trigger_flag_in = trigger_flag_ff;
      freq_timer_in = freq_timer_ff;
      shift_reg_in = shift_reg_ff;
      enabled_in = enabled_ff;
      env_running_in = env_running_ff;
      out_volume_in = out_volume_ff;
      rd = 8'd0;
      d = item.write_data;
      fb = shift_reg_ff[0] ^ shift_reg_ff[1];
      sr = {fb, shift_reg_ff[14:1]};
      vol = volume_ff;
      len = length_count_ff - 7'd1;

      case (item.func)
         FUNC_READ: begin
            case (item.reg_offset)
               REG_NR41: rd = {2'b00, length_load_ff};
               REG_NR42: rd = {volume_load_ff, env_increase_ff, env_period_load_ff};
               REG_NR43: rd = {clock_shift_ff, narrow_mode_ff, divisor_code_ff};
               REG_NR44: rd = {trigger_flag_ff, length_enable_ff, 6'd0};
               default: rd = 8'd0;
            endcase
         end
         FUNC_WRITE: begin
            case (item.reg_offset)
               REG_NR41: begin
                  length_load_in = d[5:0];
                  length_count_in = LENGTH_FULL - {1'b0, d[5:0]};
               end
               REG_NR42: begin
                  dac_on_in = (d & DAC_MASK) != 8'd0;
                  volume_load_in = d[7:4];
                  env_increase_in = d[3];
                  env_period_load_in = d[2:0];
                  env_period_count_in = {1'b0, d[2:0]};
                  volume_in = d[7:4];
               end
               REG_NR43: begin
                  divisor_code_in = d[2:0];
                  narrow_mode_in = d[3];
                  clock_shift_in = d[7:4];
               end
               REG_NR44: begin
                  length_enable_in = d[6];
                  trigger_flag_in = d[7];
                  if (d[7]) begin
                     enabled_in = 1'b1;
                     if (length_count_ff == 7'd0) begin
                        length_count_in = LENGTH_FULL;
                     end
                     freq_timer_in = timer_period(divisor_code_ff, clock_shift_ff);
                     env_period_count_in = {1'b0, env_period_load_ff};
                     env_running_in = 1'b1;
                     volume_in = volume_load_ff;
                     shift_reg_in = LFSR_ALL_ONES;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_FREQ_TICK: begin
            if (freq_timer_ff > {{(TIMER_W-1){1'b0}}, 1'b1}) begin
               freq_timer_in = freq_timer_ff - {{(TIMER_W-1){1'b0}}, 1'b1};
            end else begin
               freq_timer_in = timer_period(divisor_code_ff, clock_shift_ff);
               if (narrow_mode_ff) begin
                  sr[6] = fb;
               end
               shift_reg_in = sr;
               if (enabled_ff && dac_on_ff && !sr[0]) begin
                  out_volume_in = volume_ff;
               end else begin
                  out_volume_in = 4'd0;
               end
            end
         end
         FUNC_ENV_TICK: begin
            if (env_period_count_ff <= 4'd1) begin
               env_period_count_in = (env_period_load_ff != 3'd0) ?
                                     {1'b0, env_period_load_ff} : ENV_RELOAD;
               if (env_running_ff && env_period_load_ff != 3'd0) begin
                  if (env_increase_ff && volume_ff < VOLUME_MAX) begin
                     vol = volume_ff + 4'd1;
                  end else if (!env_increase_ff && volume_ff > 4'd0) begin
                     vol = volume_ff - 4'd1;
                  end
               end
               volume_in = vol;
               if (vol == 4'd0 || vol == VOLUME_MAX) begin
                  env_running_in = 1'b0;
               end
            end else begin
               env_period_count_in = env_period_count_ff - 4'd1;
            end
         end
         FUNC_LEN_TICK: begin
            if (length_count_ff != 7'd0 && length_enable_ff) begin
               length_count_in = len;
               if (len == 7'd0) begin
                  enabled_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      result.read_data = rd;
      result.sample_volume = out_volume_in;
      result.length_running = length_count_in != 7'd0;
      result.channel_on = enabled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_load_ff <= '0;
         length_count_ff <= '0;
         dac_on_ff <= 1'b0;
         volume_load_ff <= '0;
         env_increase_ff <= 1'b0;
         env_period_load_ff <= '0;
         env_period_count_ff <= '0;
         volume_ff <= '0;
         divisor_code_ff <= '0;
         narrow_mode_ff <= 1'b0;
         clock_shift_ff <= '0;
         length_enable_ff <= 1'b0;
         trigger_flag_ff <= 1'b0;
         freq_timer_ff <= '0;
         shift_reg_ff <= LFSR_ALL_ONES;
         enabled_ff <= 1'b0;
         env_running_ff <= 1'b0;
         out_volume_ff <= '0;
      end else if (step) begin
         length_load_ff <= length_load_in;
         length_count_ff <= length_count_in;
         dac_on_ff <= dac_on_in;
         volume_load_ff <= volume_load_in;
         env_increase_ff <= env_increase_in;
         env_period_load_ff <= env_period_load_in;
         env_period_count_ff <= env_period_count_in;
         volume_ff <= volume_in;
         divisor_code_ff <= divisor_code_in;
         narrow_mode_ff <= narrow_mode_in;
         clock_shift_ff <= clock_shift_in;
         length_enable_ff <= length_enable_in;
         trigger_flag_ff <= trigger_flag_in;
         freq_timer_ff <= freq_timer_in;
         shift_reg_ff <= shift_reg_in;
         enabled_ff <= enabled_in;
         env_running_ff <= env_running_in;
         out_volume_ff <= out_volume_in;
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      length_count_ff <= LENGTH_FULL)
      else $error("length counter above full scale");

   assert property (@(posedge clock) disable iff (reset)
      env_period_count_ff <= ENV_RELOAD)
      else $error("envelope count out of range");

   assert property (@(posedge clock) disable iff (reset)
      step && item.func == FUNC_WRITE && item.reg_offset == REG_NR44 && item.write_data[7]
      |=> enabled_ff && shift_reg_ff == LFSR_ALL_ONES && length_count_ff != 7'd0)
      else $error("trigger did not start the channel");

   assert property (@(posedge clock) disable iff (reset)
      step && item.func == FUNC_FREQ_TICK && freq_timer_ff > {{(TIMER_W-1){1'b0}}, 1'b1}
      |=> freq_timer_ff == $past(freq_timer_ff) - {{(TIMER_W-1){1'b0}}, 1'b1}
          && $stable(shift_reg_ff))
      else $error("frequency timer did not count down");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/noise_channel_lfsr_envelope.sv -----
// noise channel top level: input register, state update, result register
//
// usage
//   req channel: one transaction per item (read, write, frequency tick,
//   envelope tick or length tick), valid/ready handshake.
//   rsp channel: exactly one result per request, in order, valid/ready.
// path: a request is held in the input register, is applied to the channel
//   state as it moves on, and its result is captured in the result register
//   and offered on rsp from then on.
// throughput: one request per cycle while rsp is not stalled; the input
//   register and the result register each hold one transaction, and the
//   state update is a single pass of logic between them.
// reset: clears the valid bits of both stages and all channel state; the lfsr comes up as
//   all ones and the timer at zero.
// stall: while a result waits and rsp_ready is low the result register holds; one more
//   request can still be taken into the input register, after which
//   req_ready drops until the result is taken.
`default_nettype none

module noise_channel_lfsr_envelope
   import nce_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire req_type req_payload,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output rsp_type rsp_payload
);

   logic in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type core_result;
   logic advance;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   nce_core u_core (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .item(in_item_ff),
      .result(core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

`default_nettype wire
